/* rtl/core/mtls_pkg.sv */
// ----------------------------------------------------------------------------
// mtls_pkg
// Shared widths and defaults for the top-left square sum block.
// ----------------------------------------------------------------------------
package mtls_pkg;

    // Field widths
    localparam int ELEM_W = 32;
    localparam int SUM_W  = 49;
    localparam int MAX_W  = 48;
    localparam int CFG_W  = 9;

    // Defaults
    localparam int MAX_SIZE_DEF = 256;
    localparam int SIZE_RST     = 256;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic        [MAX_W-1:0]  max_sum_t;
    typedef logic        [CFG_W-1:0]  size_cfg_t;

endpackage

/* rtl/core/mtls_if.sv */
// ----------------------------------------------------------------------------
// mtls_if
// Valid/ready channels for elements, results and the size register.
// ----------------------------------------------------------------------------
interface mtls_elem_if;
    logic            valid;
    logic            ready;
    mtls_pkg::elem_t element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface mtls_result_if;
    logic               valid;
    logic               ready;
    mtls_pkg::max_sum_t max_square_sum;
    mtls_pkg::sum_t     total_sum;

    modport source (output valid, output max_square_sum, output total_sum, input ready);
    modport sink   (input valid, input max_square_sum, input total_sum, output ready);
endinterface

interface mtls_cfg_if;
    logic                valid;
    logic                ready;
    mtls_pkg::size_cfg_t matrix_size;

    modport source (output valid, output matrix_size, input ready);
    modport sink   (input valid, input matrix_size, output ready);
endinterface

/* rtl/core/mtls_ram.sv */
// ----------------------------------------------------------------------------
// mtls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mtls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/max_top_left_square_sum.sv */
// ----------------------------------------------------------------------------
// max_top_left_square_sum
// Largest top-left k-by-k square sum over a streamed signed square matrix.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one matrix element per transaction, row-major order.
//   out_ch : one transaction per matrix, after its last element, carrying the
//            largest top-left square sum (at least zero) and the matrix total.
//   cfg    : writes matrix_size (0 counts as 1, values above MAX_SIZE clamp).
//            A write restarts the matrix; write only while the block is idle.
// Throughput: one element per cycle unless stalled. Each element reads its
//   column sum from the column RAM at acceptance; elements above the diagonal
//   write it back in the next cycle. A column is touched again no sooner than
//   one row later, so no forwarding is needed.
// Stall: the result waits in an output register. Elements keep flowing while
//   it waits; only a second matrix end meeting a still-full output register
//   holds in_ch.ready low.
// Reset: counters and sums clear, matrix_size returns to 256 (clamped to
//   MAX_SIZE). The column RAM is not cleared; row 0 writes it before use.
// ----------------------------------------------------------------------------
module max_top_left_square_sum #(
    parameter int MAX_SIZE = mtls_pkg::MAX_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mtls_elem_if.sink    in_ch,
    mtls_result_if.source out_ch,
    mtls_cfg_if.sink     cfg
);

    import mtls_pkg::*;

    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int RST_SIZE = (SIZE_RST > MAX_SIZE) ? MAX_SIZE : SIZE_RST;
    localparam logic [IDX_W-1:0] LAST_RST = IDX_W'(RST_SIZE - 1);

    // Size and position
    logic [IDX_W-1:0] size_last_reg, size_last_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;

    // Execute stage
    logic             s1_valid_reg, s1_valid_next;
    elem_t            s1_elem_reg;
    logic [IDX_W-1:0] s1_row_reg;
    logic [IDX_W-1:0] s1_col_reg;
    logic             s1_last_reg;

    // Sums
    sum_t row_partial_reg, row_partial_next;
    sum_t total_reg, total_next;
    sum_t best_reg, best_next;

    // Output register
    logic     out_valid_reg, out_valid_next;
    max_sum_t out_max_reg;
    sum_t     out_total_reg;

    logic        in_fire;
    logic        cfg_fire;
    logic        s1_stall;
    logic        s1_fire;
    logic [31:0] cfg_wide;
    sum_t        elem_ext;
    sum_t        col_rd;
    sum_t        col_val;
    sum_t        diag_total;
    logic        ram_wr_en;
    sum_t        ram_wr_data;

    // Handshakes
    assign s1_stall    = s1_valid_reg && s1_last_reg && out_valid_reg && !out_ch.ready;
    assign s1_fire     = s1_valid_reg && !s1_stall;
    assign in_ch.ready = !s1_stall;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;
    assign cfg_fire    = cfg.valid && cfg.ready;

    // Clamp the written size to 1..MAX_SIZE and keep it as a last index
    assign cfg_wide = 32'(cfg.matrix_size);
    always_comb
    begin
        size_last_next = size_last_reg;
        if (cfg_fire)
        begin
            if (cfg_wide == 32'd0)
            begin
                size_last_next = '0;
            end
            else if (cfg_wide > 32'(MAX_SIZE))
            begin
                size_last_next = IDX_W'(MAX_SIZE - 1);
            end
            else
            begin
                size_last_next = IDX_W'(cfg_wide - 32'd1);
            end
        end
    end

    // Advance row and column on each accepted element; a size write resets both
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_fire)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (in_fire)
        begin
            if (col_reg == size_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == size_last_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign s1_valid_next = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    // Column sum store
    mtls_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SIZE)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wr_data),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (col_rd)
    );

    // Execute: row partial, column update or diagonal border
    assign elem_ext   = {{(SUM_W-ELEM_W){s1_elem_reg[ELEM_W-1]}}, s1_elem_reg};
    assign col_val    = (s1_col_reg == '0) ? '0 : col_rd;
    assign diag_total = total_reg + row_partial_reg + elem_ext + col_val;
    assign ram_wr_en  = s1_fire && (s1_col_reg > s1_row_reg);
    assign ram_wr_data = (s1_row_reg == '0) ? elem_ext : col_rd + elem_ext;

    always_comb
    begin
        row_partial_next = row_partial_reg;
        total_next       = total_reg;
        best_next        = best_reg;
        if (cfg_fire)
        begin
            row_partial_next = '0;
            total_next       = '0;
            best_next        = '0;
        end
        else if (s1_fire)
        begin
            if (s1_col_reg < s1_row_reg)
            begin
                row_partial_next = row_partial_reg + elem_ext;
            end
            else if (s1_col_reg == s1_row_reg)
            begin
                row_partial_next = '0;
                if (s1_last_reg)
                begin
                    total_next = '0;
                    best_next  = '0;
                end
                else
                begin
                    total_next = diag_total;
                    best_next  = (diag_total > best_reg) ? diag_total : best_reg;
                end
            end
        end
    end

    // Output register: load on matrix end, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_last_reg   <= LAST_RST;
            row_reg         <= '0;
            col_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            row_partial_reg <= '0;
            total_reg       <= '0;
            best_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            size_last_reg   <= size_last_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            s1_valid_reg    <= s1_valid_next;
            row_partial_reg <= row_partial_next;
            total_reg       <= total_next;
            best_reg        <= best_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_elem_reg <= in_ch.element;
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_last_reg <= (row_reg == size_last_reg) && (col_reg == size_last_reg);
        end
        if (s1_fire && s1_last_reg)
        begin
            out_max_reg   <= max_sum_t'(((diag_total > best_reg) ? diag_total : best_reg));
            out_total_reg <= diag_total;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.max_square_sum = out_max_reg;
    assign out_ch.total_sum      = out_total_reg;

endmodule
